// ===== hdl/hmd5_pkg.sv =====
// hmd5_pkg: shared types, constants and round tables for the HMAC-MD5 hex digest block.
// Depends on nothing; imported by the top level, hmd5_ctrl and hmd5_datapath.
`timescale 1ns / 1ps
package hmd5_pkg;

   localparam int KeyWords   = 8;
   localparam int KeyWidth   = 64;
   localparam int CsrIdxW    = 3;
   localparam int CountW     = 29;
   localparam int DigestChars = 32;
   localparam int KeyPadBytes = 64;

   localparam logic [7:0] IPAD = 8'h36;
   localparam logic [7:0] OPAD = 8'h5c;
   localparam logic [31:0] IV0 = 32'h67452301;
   localparam logic [31:0] IV1 = 32'hefcdab89;
   localparam logic [31:0] IV2 = 32'h98badcfe;
   localparam logic [31:0] IV3 = 32'h10325476;

   // source of the next 64-byte block to compress
   typedef enum logic [1:0] {
      SRC_IPAD, SRC_BUF, SRC_OPAD
   } src_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_OPEN, ST_WAIT_OPEN, ST_BYTE, ST_WAIT_BYTE,
      ST_PAD, ST_WAIT_PAD, ST_OUTER_KEY, ST_WAIT_OK, ST_OUTER_FIN,
      ST_WAIT_OF, ST_EMIT
   } state_type;

   typedef struct packed {
      logic    chain_init;   // load IV
      logic    start;        // start a compression
      src_type src;
      logic    write_byte;   // append request byte to buffer
      logic    pad_block;    // pad the buffer after the last data byte
      logic    pad_stage;    // 0: first pad block, 1: length-only block
      logic    build_inner;  // build outer message block from inner digest
      logic    save_inner;   // latch chain as inner digest
      logic    preset_count; // count the key pad block
      logic    emit_load;
   } cmd_type;

   typedef struct packed {
      logic       busy;
      logic       block_full;
      logic [5:0] fill;
   } sts_type;

   function automatic logic [31:0] sine_k(input logic [5:0] i);
      logic [31:0] t [64];
      t = '{
         32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
         32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
         32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
         32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
         32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
         32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
         32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
         32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
         32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
         32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
         32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
         32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
         32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
         32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
         32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
         32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
      return t[i];
   endfunction

   function automatic logic [4:0] rot_s(input logic [3:0] i);
      logic [4:0] t [16];
      t = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
            5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
      return t[i];
   endfunction

   function automatic logic [6:0] hex_ascii(input logic [3:0] n);
      return (n < 4'd10) ? 7'(7'h30 + n) : 7'(7'h37 + n);
   endfunction

endpackage

// ===== hdl/hmac_md5_hex_digest.sv =====
// HMAC-MD5 over a byte stream, digest out as 32 upper-case hex characters.
// Opening compresses the ipad key block; each byte goes to the block buffer and a full
// block is compressed; the last item adds 3-4 compressions before the 32 characters.
// Throughput: a request is taken only after the last is done; set by the one-round MD5 unit.
// Reset: synchronous, active high; clears key words, the sequencer and byte count.
// Depends on hmd5_pkg, hmd5_ctrl, hmd5_datapath.
`timescale 1ns / 1ps
module hmac_md5_hex_digest (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_message_byte,
   input  logic       req_byte_present,
   input  logic       req_last_item,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_hex_char,
   output logic       rsp_last_char,
   input  logic       csr_write_enable,
   input  logic [hmd5_pkg::CsrIdxW-1:0] csr_index,
   input  logic [hmd5_pkg::KeyWidth-1:0] csr_write_data
);
   import hmd5_pkg::*;

   logic [KeyWords*KeyWidth-1:0] key_ff;
   logic [7:0] byte_ff;
   cmd_type cmd;
   sts_type sts;
   logic [4:0] char_idx;

   always_ff @(posedge clock) begin
      if (reset) key_ff <= '0;
      else if (csr_write_enable) key_ff[KeyWidth*csr_index +: KeyWidth] <= csr_write_data;
      if (req_valid && req_ready) byte_ff <= req_message_byte;
   end

   hmd5_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_byte_present, .req_last_item,
      .rsp_valid, .rsp_ready, .rsp_last_char, .char_idx, .cmd, .sts
   );

   hmd5_datapath u_dp (
      .clock, .reset, .cmd, .sts, .req_message_byte(byte_ff), .key_flat(key_ff),
      .char_idx, .char_out(rsp_hex_char)
   );
endmodule

// ===== hdl/hmd5_datapath.sv =====
// hmd5_datapath: block buffer, MD5 round unit (one round per cycle), chain and digest registers.
// Depends on hmd5_pkg; driven by hmd5_ctrl.
`timescale 1ns / 1ps
module hmd5_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  hmd5_pkg::cmd_type     cmd,
   output hmd5_pkg::sts_type     sts,
   input  logic [7:0]            req_message_byte,
   input  logic [hmd5_pkg::KeyWords*hmd5_pkg::KeyWidth-1:0] key_flat,
   input  logic [4:0]            char_idx,
   output logic [6:0]            char_out
);
   import hmd5_pkg::*;

   logic [31:0] buf_ff [16];
   logic [31:0] buf_in [16];
   logic [CountW-1:0] count_ff, count_in;
   logic [31:0] chain_ff [4];
   logic [31:0] chain_in [4];
   logic [31:0] inner_ff [4];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, a_in, b_in, c_in, d_in;
   logic [5:0]  round_ff, round_in;
   logic        busy_ff, busy_in;
   src_type     src_ff, src_in;
   logic [511:0] blk;
   logic [31:0] f, w, t, rot;
   logic [3:0]  k;
   logic [1:0]  ph;
   logic [5:0]  m;
   logic [31:0] bitlen;

   assign m = count_ff[5:0];
   assign bitlen = {count_ff, 3'b000};

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         case (src_ff)
            SRC_IPAD: blk[32*i +: 32] = key_flat[32*i +: 32] ^ {4{IPAD}};
            SRC_OPAD: blk[32*i +: 32] = key_flat[32*i +: 32] ^ {4{OPAD}};
            default:  blk[32*i +: 32] = buf_ff[i];
         endcase
      end
   end

   always_comb begin
      ph = round_ff[5:4];
      unique case (ph)
         2'd0: begin f = (b_ff & c_ff) | (~b_ff & d_ff); k = round_ff[3:0]; end
         2'd1: begin
            f = (b_ff & d_ff) | (c_ff & ~d_ff);
            k = 4'(5 * round_ff + 1);
         end
         2'd2: begin f = b_ff ^ c_ff ^ d_ff; k = 4'(3 * round_ff + 5); end
         default: begin f = c_ff ^ (b_ff | ~d_ff); k = 4'(7 * round_ff); end
      endcase
      w = blk[32*k +: 32];
      t = a_ff + f + w + sine_k(round_ff);
      rot = (t << rot_s({ph, round_ff[1:0]})) | (t >> (6'd32 - rot_s({ph, round_ff[1:0]})));
   end

   always_comb begin
      buf_in = buf_ff;
      count_in = count_ff;
      chain_in = chain_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff;
      round_in = round_ff;
      busy_in = busy_ff;
      src_in = src_ff;
      if (cmd.preset_count) count_in = CountW'(KeyPadBytes);
      if (cmd.write_byte) begin
         buf_in[m[5:2]][8*m[1:0] +: 8] = req_message_byte;
         count_in = count_ff + 1'b1;
      end
      if (cmd.pad_block) begin
         // first pad block; length goes in if it fits
         for (int i = 0; i < 64; i++)
            if (i > m) buf_in[4'(i >> 2)][8*(i & 3) +: 8] = 8'h00;
         buf_in[m[5:2]][8*m[1:0] +: 8] = 8'h80;
         if (m < 6'd56) buf_in[14] = bitlen;
      end
      if (cmd.pad_stage && cmd.start) begin
         for (int i = 0; i < 16; i++) buf_in[i] = 32'h0;
         buf_in[14] = bitlen;
      end
      if (cmd.build_inner) begin
         for (int i = 0; i < 16; i++) buf_in[i] = 32'h0;
         for (int i = 0; i < 4; i++) buf_in[i] = inner_ff[i];
         buf_in[4] = 32'h0000_0080;
         buf_in[14] = 32'h0000_0280;   // 80*8 = 640 bits
      end
      if (cmd.chain_init) begin
         chain_in[0] = IV0; chain_in[1] = IV1; chain_in[2] = IV2; chain_in[3] = IV3;
      end
      if (cmd.start) begin
         busy_in = 1'b1;
         src_in = cmd.src;
         round_in = '0;
         a_in = cmd.chain_init ? IV0 : chain_ff[0];
         b_in = cmd.chain_init ? IV1 : chain_ff[1];
         c_in = cmd.chain_init ? IV2 : chain_ff[2];
         d_in = cmd.chain_init ? IV3 : chain_ff[3];
      end else if (busy_ff) begin
         a_in = d_ff; d_in = c_ff; c_in = b_ff; b_in = b_ff + rot;
         round_in = round_ff + 1'b1;
         if (round_ff == 6'd63) begin
            busy_in = 1'b0;
            chain_in[0] = chain_ff[0] + d_ff;
            chain_in[1] = chain_ff[1] + b_ff + rot;
            chain_in[2] = chain_ff[2] + b_ff;
            chain_in[3] = chain_ff[3] + c_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      chain_ff <= chain_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in;
      if (cmd.save_inner) inner_ff <= chain_ff;
      if (reset) begin
         busy_ff <= 1'b0;
         count_ff <= '0;
         round_ff <= '0;
         src_ff <= SRC_BUF;
      end else begin
         busy_ff <= busy_in;
         count_ff <= count_in;
         round_ff <= round_in;
         src_ff <= src_in;
      end
   end

   logic [31:0] cw;
   logic [7:0]  cb;
   always_comb begin
      cw = chain_ff[char_idx[4:3]];
      cb = cw[8*char_idx[2:1] +: 8];
      char_out = hex_ascii(char_idx[0] ? cb[3:0] : cb[7:4]);
   end

   assign sts.busy = busy_ff;
   assign sts.fill = m;
   assign sts.block_full = (m == 6'd63);
endmodule

// ===== hdl/hmd5_ctrl.sv =====
// hmd5_ctrl: sequencer for opening, byte absorb, padding, outer hash and hex emit.
// Depends on hmd5_pkg; commands hmd5_datapath.
`timescale 1ns / 1ps
module hmd5_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_byte_present,
   input  logic              req_last_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_last_char,
   output logic [4:0]        char_idx,
   output hmd5_pkg::cmd_type cmd,
   input  hmd5_pkg::sts_type sts
);
   import hmd5_pkg::*;

   state_type state_ff, state_in;
   logic open_ff, open_in, pres_ff, pres_in, last_ff, last_in, wrap_ff, wrap_in;
   logic [4:0] idx_ff, idx_in;

   assign char_idx = idx_ff;
   assign rsp_last_char = (idx_ff == 5'(DigestChars - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         open_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         open_ff <= open_in;
         idx_ff <= idx_in;
      end
      pres_ff <= pres_in;
      last_ff <= last_in;
      wrap_ff <= wrap_in;
   end

   always_comb begin
      state_in = state_ff;
      open_in = open_ff;
      pres_in = pres_ff;
      last_in = last_ff;
      wrap_in = wrap_ff;
      idx_in = idx_ff;
      cmd = '0;
      cmd.src = SRC_BUF;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               pres_in = req_byte_present;
               last_in = req_last_item;
               state_in = open_ff ? ST_BYTE : ST_OPEN;
            end
         end
         ST_OPEN: begin
            cmd.chain_init = 1'b1;
            cmd.start = 1'b1;
            cmd.src = SRC_IPAD;
            cmd.preset_count = 1'b1;
            open_in = 1'b1;
            state_in = ST_WAIT_OPEN;
         end
         ST_WAIT_OPEN: if (!sts.busy) state_in = ST_BYTE;
         ST_BYTE: begin
            if (pres_ff) begin
               cmd.write_byte = 1'b1;
               if (sts.block_full) begin
                  state_in = ST_WAIT_BYTE;
               end else begin
                  state_in = last_ff ? ST_PAD : ST_IDLE;
               end
            end else begin
               state_in = last_ff ? ST_PAD : ST_IDLE;
            end
         end
         ST_WAIT_BYTE: begin
            // full buffer: compress it
            cmd.start = 1'b1;
            state_in = ST_WAIT_PAD;
            wrap_in = 1'b1;
         end
         ST_PAD: begin
            cmd.start = 1'b1;
            cmd.pad_block = 1'b1;
            wrap_in = 1'b0;
            state_in = ST_WAIT_PAD;
            pres_in = (sts.fill >= 6'd56);
         end
         ST_WAIT_PAD: begin
            if (!sts.busy) begin
               if (wrap_ff) begin
                  wrap_in = 1'b0;
                  state_in = last_ff ? ST_PAD : ST_IDLE;
               end else if (pres_ff) begin
                  cmd.start = 1'b1;
                  cmd.pad_stage = 1'b1;
                  pres_in = 1'b0;
               end else begin
                  cmd.save_inner = 1'b1;
                  state_in = ST_OUTER_KEY;
               end
            end
         end
         ST_OUTER_KEY: begin
            cmd.chain_init = 1'b1;
            cmd.start = 1'b1;
            cmd.src = SRC_OPAD;
            cmd.build_inner = 1'b1;
            state_in = ST_WAIT_OK;
         end
         ST_WAIT_OK: if (!sts.busy) state_in = ST_OUTER_FIN;
         ST_OUTER_FIN: begin
            cmd.start = 1'b1;
            cmd.build_inner = 1'b0;
            state_in = ST_WAIT_OF;
         end
         ST_WAIT_OF: if (!sts.busy) begin
            idx_in = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               idx_in = idx_ff + 1'b1;
               if (rsp_last_char) begin
                  open_in = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

// ===== hdl/hmd5_checker.sv =====
// hmd5_checker: port-level assertions for hmac_md5_hex_digest, with its bind.
// Depends on the top level's ports only.
`timescale 1ns / 1ps
module hmd5_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [6:0] rsp_hex_char,
   input logic       rsp_last_char
);
   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while digest pending");
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_hex_char >= 7'h30 && rsp_hex_char <= 7'h39) ||
                     (rsp_hex_char >= 7'h41 && rsp_hex_char <= 7'h46)))
      else $error("bad hex char");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hex_char))
      else $error("response dropped");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_char |=> !rsp_valid)
      else $error("extra chars after last");
endmodule

bind hmac_md5_hex_digest hmd5_checker u_chk (.*);
